// ===== rtl/ac3sfp_pkg.sv =====
`default_nettype none

package ac3sfp_pkg;

    // Parse phases, also shown on the phase output.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Status codes carried with each output word.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_GAP     = 2'd3;

    // Sync word bytes in stream order.
    localparam logic [7:0] SYNC_FIRST  = 8'h0B;
    localparam logic [7:0] SYNC_SECOND = 8'h77;

    // Header byte positions.
    localparam logic [11:0] HDR_FIRST_IDX = 12'd2;
    localparam logic [11:0] HDR_FS_IDX    = 12'd4;
    localparam logic [11:0] HDR_LAST_IDX  = 12'd6;
    localparam logic [11:0] HDR_LEN       = 12'd7;

    localparam logic [15:0] SKIP_MAX      = 16'hFFFF;
    localparam logic [15:0] MAX_GAP_RESET = 16'd32768;

    // Sample rate codes and frame size code limit.
    localparam logic [1:0] FS_48K      = 2'd0;
    localparam logic [1:0] FS_44K      = 2'd1;
    localparam logic [1:0] FS_32K      = 2'd2;
    localparam logic [1:0] FS_RESERVED = 2'd3;
    localparam logic [5:0] CODE_COUNT  = 6'd38;

    // At 48 kHz and 32 kHz the frame duration does not depend on the bitrate.
    localparam logic [25:0] DUR_48K = 26'd32000000;
    localparam logic [25:0] DUR_32K = 26'd48000000;

    localparam logic [9:0] KBPS_ROM [38] = '{
        10'd32,  10'd32,  10'd40,  10'd40,  10'd48,  10'd48,  10'd56,  10'd56,
        10'd64,  10'd64,  10'd80,  10'd80,  10'd96,  10'd96,  10'd112, 10'd112,
        10'd128, 10'd128, 10'd160, 10'd160, 10'd192, 10'd192, 10'd224, 10'd224,
        10'd256, 10'd256, 10'd320, 10'd320, 10'd384, 10'd384, 10'd448, 10'd448,
        10'd512, 10'd512, 10'd576, 10'd576, 10'd640, 10'd640
    };

    // Word counts at 44.1 kHz; the other rates are two and three words per kbit/s.
    localparam logic [10:0] WORDS_44K_ROM [38] = '{
        11'd69,   11'd70,   11'd87,   11'd88,   11'd104,  11'd105,  11'd121,  11'd122,
        11'd139,  11'd140,  11'd174,  11'd175,  11'd208,  11'd209,  11'd243,  11'd244,
        11'd278,  11'd279,  11'd348,  11'd349,  11'd417,  11'd418,  11'd487,  11'd488,
        11'd557,  11'd558,  11'd696,  11'd697,  11'd835,  11'd836,  11'd975,  11'd976,
        11'd1114, 11'd1115, 11'd1253, 11'd1254, 11'd1393, 11'd1394
    };

    // Frame duration in ns at 44.1 kHz, bytes * 8000000 / kbps truncated.
    localparam logic [25:0] DUR_44K_ROM [38] = '{
        26'd34500000, 26'd35000000, 26'd34800000, 26'd35200000,
        26'd34666666, 26'd35000000, 26'd34571428, 26'd34857142,
        26'd34750000, 26'd35000000, 26'd34800000, 26'd35000000,
        26'd34666666, 26'd34833333, 26'd34714285, 26'd34857142,
        26'd34750000, 26'd34875000, 26'd34800000, 26'd34900000,
        26'd34750000, 26'd34833333, 26'd34785714, 26'd34857142,
        26'd34812500, 26'd34875000, 26'd34800000, 26'd34850000,
        26'd34791666, 26'd34833333, 26'd34821428, 26'd34857142,
        26'd34812500, 26'd34843750, 26'd34805555, 26'd34833333,
        26'd34825000, 26'd34850000
    };

    // Full-bandwidth channels for each audio coding mode.
    localparam logic [2:0] CHAN_ROM [8] = '{
        3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
    };

    // Decoded header fields handed from the decoder to the parser core.
    typedef struct packed {
        logic        ok;
        logic [1:0]  fs;
        logic [9:0]  kbps;
        logic [11:0] bytes;
        logic [2:0]  channels;
        logic        lfe;
        logic [25:0] duration;
    } dec_t;

    // One output word.
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  phase;
        logic [1:0]  status;
        logic        frame_end;
        logic [1:0]  sample_rate_code;
        logic [9:0]  bitrate_kbps;
        logic [11:0] frame_bytes;
        logic [2:0]  channels;
        logic        lfe;
        logic [25:0] duration_ns;
        logic [15:0] skipped_bytes;
    } res_t;

    function automatic logic [9:0] kbps_lookup(input logic [5:0] code);
        logic [9:0] v;
        v = '0;
        if (code < CODE_COUNT)
            v = KBPS_ROM[code];
        return v;
    endfunction

    function automatic logic [10:0] words_lookup(input logic [1:0] fs,
                                                 input logic [5:0] code);
        logic [10:0] k;
        logic [10:0] v;
        k = {1'b0, kbps_lookup(code)};
        v = '0;
        case (fs)
            FS_48K: v = {k[9:0], 1'b0};
            FS_44K: if (code < CODE_COUNT) v = WORDS_44K_ROM[code];
            FS_32K: v = k * 11'd3;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [25:0] dur_lookup(input logic [1:0] fs,
                                               input logic [5:0] code);
        logic [25:0] v;
        v = '0;
        case (fs)
            FS_48K: v = DUR_48K;
            FS_44K: if (code < CODE_COUNT) v = DUR_44K_ROM[code];
            FS_32K: v = DUR_32K;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ac3sfp_decode.sv =====
`default_nettype none

module ac3sfp_decode #(
    parameter int MAX_FRAME_BYTES = 3840
) (
    input  wire logic [7:0]        hdr4,
    input  wire logic [7:0]        hdr6,
    output ac3sfp_pkg::dec_t       dec
);

    localparam logic [12:0] MaxBytes = 13'(MAX_FRAME_BYTES);

    logic [1:0]  fs;
    logic [5:0]  code;
    logic [2:0]  acmod;
    logic [11:0] bytes;
    logic [1:0]  extra;
    logic        lfe_bit;

    assign fs    = hdr4[7:6];
    assign code  = hdr4[5:0];
    assign acmod = hdr6[7:5];
    assign bytes = {ac3sfp_pkg::words_lookup(fs, code), 1'b0};

    // Count the 2-bit mix level fields that precede the LFE bit.
    always_comb
    begin
        extra = 2'd0;
        if (acmod[0] && (acmod != 3'd1))
            extra = extra + 2'd1;
        if (acmod[2])
            extra = extra + 2'd1;
        if (acmod == 3'd2)
            extra = extra + 2'd1;
    end

    // Pick the LFE bit after those fields.
    always_comb
    begin
        case (extra)
            2'd0:    lfe_bit = hdr6[4];
            2'd1:    lfe_bit = hdr6[2];
            2'd2:    lfe_bit = hdr6[0];
            default: lfe_bit = hdr6[0];
        endcase
    end

    // Header fields from the ROM tables.
    always_comb
    begin
        dec.ok       = (fs != ac3sfp_pkg::FS_RESERVED) && (code < ac3sfp_pkg::CODE_COUNT)
                       && ({1'b0, bytes} <= MaxBytes);
        dec.fs       = fs;
        dec.kbps     = ac3sfp_pkg::kbps_lookup(code);
        dec.bytes    = bytes;
        dec.channels = ac3sfp_pkg::CHAN_ROM[acmod] + {2'b00, lfe_bit};
        dec.lfe      = lfe_bit;
        dec.duration = ac3sfp_pkg::dur_lookup(fs, code);
    end

endmodule

`default_nettype wire

// ===== rtl/ac3sfp_core.sv =====
`default_nettype none

module ac3sfp_core #(
    parameter int MAX_FRAME_BYTES = 3840
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        byte_in,
    input  wire logic [15:0]       max_gap,
    output ac3sfp_pkg::res_t       res
);

    logic [1:0]  phase_reg,      phase_next;
    logic [7:0]  prev_reg,       prev_next;
    logic        prev_valid_reg, prev_valid_next;
    logic [7:0]  hdr4_reg,       hdr4_next;
    logic [11:0] index_reg,      index_next;
    logic [11:0] flen_reg,       flen_next;
    logic [15:0] skip_reg,       skip_next;

    logic [11:0]       index_inc;
    logic [15:0]       skip_inc;
    ac3sfp_pkg::dec_t  dec;

    // Header byte 6, the last one, arrives as the current byte.
    ac3sfp_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .hdr4 (hdr4_reg),
        .hdr6 (byte_in),
        .dec  (dec)
    );

    assign index_inc = index_reg + 12'd1;
    assign skip_inc  = skip_reg + 16'd1;

    // Per-byte parse step and result word.
    always_comb
    begin
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        hdr4_next       = hdr4_reg;
        index_next      = index_reg;
        flen_next       = flen_reg;
        skip_next       = skip_reg;
        res             = '0;
        res.byte_out    = byte_in;

        case (phase_reg)
            ac3sfp_pkg::PH_HEAD:
            begin
                res.phase  = ac3sfp_pkg::PH_HEAD;
                index_next = index_inc;
                if (index_reg == ac3sfp_pkg::HDR_FS_IDX)
                    hdr4_next = byte_in;
                if (index_reg == ac3sfp_pkg::HDR_LAST_IDX)
                begin
                    res.skipped_bytes = skip_reg;
                    skip_next         = '0;
                    if (dec.ok)
                    begin
                        res.status           = ac3sfp_pkg::ST_VALID;
                        res.sample_rate_code = dec.fs;
                        res.bitrate_kbps     = dec.kbps;
                        res.frame_bytes      = dec.bytes;
                        res.channels         = dec.channels;
                        res.lfe              = dec.lfe;
                        res.duration_ns      = dec.duration;
                        phase_next           = ac3sfp_pkg::PH_BODY;
                        index_next           = ac3sfp_pkg::HDR_LEN;
                        flen_next            = dec.bytes;
                    end
                    else
                    begin
                        // This byte may still open the next sync word.
                        res.status      = ac3sfp_pkg::ST_INVALID;
                        phase_next      = ac3sfp_pkg::PH_HUNT;
                        index_next      = '0;
                        prev_next       = byte_in;
                        prev_valid_next = 1'b1;
                    end
                end
            end

            ac3sfp_pkg::PH_BODY:
            begin
                res.phase  = ac3sfp_pkg::PH_BODY;
                index_next = index_inc;
                if (index_inc >= flen_reg)
                begin
                    res.frame_end   = 1'b1;
                    phase_next      = ac3sfp_pkg::PH_HUNT;
                    index_next      = '0;
                    prev_valid_next = 1'b0;
                end
            end

            default:
            begin
                phase_next = ac3sfp_pkg::PH_HUNT;
                if (prev_valid_reg && (prev_reg == ac3sfp_pkg::SYNC_FIRST)
                    && (byte_in == ac3sfp_pkg::SYNC_SECOND))
                begin
                    res.phase       = ac3sfp_pkg::PH_HEAD;
                    phase_next      = ac3sfp_pkg::PH_HEAD;
                    index_next      = ac3sfp_pkg::HDR_FIRST_IDX;
                    prev_valid_next = 1'b0;
                end
                else
                begin
                    // The previous byte is now known to be skipped.
                    res.skipped_bytes = skip_reg;
                    if (prev_valid_reg && (skip_reg != ac3sfp_pkg::SKIP_MAX))
                    begin
                        skip_next         = skip_inc;
                        res.skipped_bytes = skip_inc;
                        if (skip_inc == max_gap)
                            res.status = ac3sfp_pkg::ST_GAP;
                    end
                    prev_next       = byte_in;
                    prev_valid_next = 1'b1;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ac3sfp_pkg::PH_HUNT;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            index_reg      <= '0;
            flen_reg       <= '0;
            skip_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            index_reg      <= index_next;
            flen_reg       <= flen_next;
            skip_reg       <= skip_next;
        end
    end

    // Stored header byte, written before it is read.
    always_ff @(posedge clk)
    begin
        if (step)
            hdr4_reg <= hdr4_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ac3_sync_frame_parser_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   data_byte
// out       output     out_valid / out_stall byte_out .. skipped_bytes
// cfg       input      cfg_valid / cfg_ready cfg_data (max_gap)
//
// One byte per cycle sustained while the output is not stalled; an accepted byte
// passes the input register, then the result register, before it shows on the output.
// The parse step between the two registers is one table lookup and a counter
// update, so the input register drains whenever the result register is free.
// Reset clears the parse state and sets max_gap to 32768; no clearing pass.
// A stall on the output holds the result word and, when the input register is full, the input.
module ac3_sync_frame_parser_unit #(
    parameter int MAX_FRAME_BYTES = 3840
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output wire logic        in_stall,
    input  wire logic [7:0]  data_byte,
    output wire logic        out_valid,
    input  wire logic        out_stall,
    output wire logic [7:0]  byte_out,
    output wire logic [1:0]  phase,
    output wire logic [1:0]  status,
    output wire logic        frame_end,
    output wire logic [1:0]  sample_rate_code,
    output wire logic [9:0]  bitrate_kbps,
    output wire logic [11:0] frame_bytes,
    output wire logic [2:0]  channels,
    output wire logic        lfe,
    output wire logic [25:0] duration_ns,
    output wire logic [15:0] skipped_bytes,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic              inb_valid_reg, inb_valid_next;
    logic [7:0]        inb_byte_reg;
    logic              out_valid_reg, out_valid_next;
    ac3sfp_pkg::res_t  out_word_reg;
    logic [15:0]       max_gap_reg;
    logic              out_free;
    logic              advance;
    logic              in_accept;
    ac3sfp_pkg::res_t  core_res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = inb_valid_reg && out_free;
    assign in_stall  = inb_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    ac3sfp_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (inb_byte_reg),
        .max_gap (max_gap_reg),
        .res     (core_res)
    );

    // Input register occupancy.
    always_comb
    begin
        inb_valid_next = inb_valid_reg;
        if (in_accept)
            inb_valid_next = 1'b1;
        else if (advance)
            inb_valid_next = 1'b0;
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inb_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            max_gap_reg   <= ac3sfp_pkg::MAX_GAP_RESET;
        end
        else
        begin
            inb_valid_reg <= inb_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                max_gap_reg <= cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            inb_byte_reg <= data_byte;
        if (advance)
            out_word_reg <= core_res;
    end

    assign out_valid        = out_valid_reg;
    assign byte_out         = out_word_reg.byte_out;
    assign phase            = out_word_reg.phase;
    assign status           = out_word_reg.status;
    assign frame_end        = out_word_reg.frame_end;
    assign sample_rate_code = out_word_reg.sample_rate_code;
    assign bitrate_kbps     = out_word_reg.bitrate_kbps;
    assign frame_bytes      = out_word_reg.frame_bytes;
    assign channels         = out_word_reg.channels;
    assign lfe              = out_word_reg.lfe;
    assign duration_ns      = out_word_reg.duration_ns;
    assign skipped_bytes    = out_word_reg.skipped_bytes;

endmodule

`default_nettype wire

// ===== rtl/ac3sfp_checker.sv =====
`default_nettype none

module ac3sfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  byte_out,
    input wire logic [1:0]  phase,
    input wire logic [1:0]  status,
    input wire logic        frame_end,
    input wire logic [9:0]  bitrate_kbps,
    input wire logic [11:0] frame_bytes,
    input wire logic [2:0]  channels,
    input wire logic        lfe,
    input wire logic [25:0] duration_ns,
    input wire logic [15:0] skipped_bytes
);

    // A valid header word is a header byte with a nonzero rate, length and duration.
    a_valid_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ac3sfp_pkg::ST_VALID)
        |-> (phase == ac3sfp_pkg::PH_HEAD) && (bitrate_kbps != 10'd0)
            && (frame_bytes != 12'd0) && (duration_ns != 26'd0))
        else $error("valid header word without header fields");

    // Header fields stay zero on every word that does not report a valid header.
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ac3sfp_pkg::ST_VALID)
        |-> (bitrate_kbps == 10'd0) && (frame_bytes == 12'd0)
            && (duration_ns == 26'd0) && (channels == 3'd0) && !lfe)
        else $error("header fields set outside a valid header word");

    // The last byte of a frame is always a body byte.
    a_frame_end_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> (phase == ac3sfp_pkg::PH_BODY))
        else $error("frame end outside the frame body");

    // A gap error comes while hunting and with a nonzero skip count.
    a_gap_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ac3sfp_pkg::ST_GAP)
        |-> (phase == ac3sfp_pkg::PH_HUNT) && (skipped_bytes != 16'd0))
        else $error("gap error outside hunting");

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(status))
        else $error("stalled output word changed");

endmodule

bind ac3_sync_frame_parser_unit ac3sfp_checker u_ac3sfp_checker (.*);

`default_nettype wire
